// ===== rtl/wsf_pkg.sv =====
// Shared types and constants for the weighted 3x3 smoothing filter.
`default_nettype none

package wsf_pkg;

  localparam int PIX_W        = 16;
  localparam int POS_W        = 10;
  localparam int CFG_W        = 11;
  localparam int MAX_SIDE_DEF = 1024;
  localparam int SIDE_RESET   = 1024;
  localparam int QDEPTH       = 4;
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  typedef logic [2:0][PIX_W-1:0] col3_t;

  // One accepted pixel that produces results: the three window columns and
  // where the window sits in the frame.
  typedef struct packed {
    col3_t            col_l;
    col3_t            col_c;
    col3_t            col_r;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             top_dup;
    logic             has_edge;
    logic             last_row;
  } wsf_rec_t;

endpackage

`default_nettype wire

// ===== rtl/wsf_front.sv =====
// Front end: pixel intake, position counters, line store and window columns.
`default_nettype none

module wsf_front #(
  parameter int MAX_SIDE = wsf_pkg::MAX_SIDE_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [wsf_pkg::CFG_W-1:0] cfg_side_length,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [wsf_pkg::PIX_W-1:0] in_pixel,
  input  wire logic [wsf_pkg::QCNT_W-1:0] q_level,
  output logic                           push,
  output wsf_pkg::wsf_rec_t              rec
);
  import wsf_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = CNT_W + 1;
  localparam int SIDE_RST = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

  logic [SIDE_W-1:0]  side_r, side_nxt;
  logic [CNT_W-1:0]   row_r, col_r;
  logic               a_valid_r;
  logic [PIX_W-1:0]   a_pix_r;
  logic [CNT_W-1:0]   a_row_r, a_col_r;
  logic               a_last_col_r, a_last_row_r;
  col3_t              win_a_r, win_b_r;
  col3_t              cur;
  logic [2*PIX_W-1:0] rd_r;
  logic [2*PIX_W-1:0] line_mem [MAX_SIDE];
  logic               accept;
  logic               last_col, last_row;
  logic [PIX_W-1:0]   newer, older;
  logic [QCNT_W:0]    occupancy;

  assign occupancy = {1'b0, q_level} + {{QCNT_W{1'b0}}, a_valid_r};
  assign in_stall  = (occupancy >= (QCNT_W + 1)'(QDEPTH));
  assign accept    = in_valid && !in_stall;

  assign last_col = (SIDE_W'(col_r) == side_r - SIDE_W'(1));
  assign last_row = (SIDE_W'(row_r) == side_r - SIDE_W'(1));

  always_comb begin
    if (cfg_side_length < 11'd2) begin
      side_nxt = SIDE_W'(2);
    end else if (32'(cfg_side_length) > MAX_SIDE) begin
      side_nxt = SIDE_W'(MAX_SIDE);
    end else begin
      side_nxt = SIDE_W'(cfg_side_length);
    end
  end

  // Each entry holds the row two above in its upper half and the row just
  // above in its lower half.
  assign newer  = rd_r[PIX_W-1:0];
  assign older  = rd_r[2*PIX_W-1:PIX_W];
  assign cur[2] = a_pix_r;
  assign cur[1] = (a_row_r != '0) ? newer : '0;
  assign cur[0] = (a_row_r > CNT_W'(1)) ? older : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem[col_r];
    end
    if (a_valid_r) begin
      line_mem[a_col_r] <= {newer, a_pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r    <= SIDE_W'(SIDE_RST);
      row_r     <= '0;
      col_r     <= '0;
      a_valid_r <= 1'b0;
      win_a_r   <= '0;
      win_b_r   <= '0;
    end else begin
      a_valid_r <= accept;
      if (cfg_we) begin
        side_r  <= side_nxt;
        row_r   <= '0;
        col_r   <= '0;
        win_a_r <= '0;
        win_b_r <= '0;
      end else begin
        if (accept) begin
          if (last_col) begin
            col_r <= '0;
            row_r <= last_row ? '0 : row_r + CNT_W'(1);
          end else begin
            col_r <= col_r + CNT_W'(1);
          end
        end
        if (a_valid_r) begin
          win_a_r <= win_b_r;
          win_b_r <= cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix_r      <= in_pixel;
      a_row_r      <= row_r;
      a_col_r      <= col_r;
      a_last_col_r <= last_col;
      a_last_row_r <= last_row;
    end
  end

  assign push = a_valid_r && (a_row_r != '0) && (a_col_r != '0);

  always_comb begin
    rec.col_l    = (a_col_r > CNT_W'(1)) ? win_a_r : win_b_r;
    rec.col_c    = win_b_r;
    rec.col_r    = cur;
    rec.row      = POS_W'(a_row_r);
    rec.col      = POS_W'(a_col_r);
    rec.top_dup  = (a_row_r == CNT_W'(1));
    rec.has_edge = a_last_col_r;
    rec.last_row = a_last_row_r;
  end

endmodule

`default_nettype wire

// ===== rtl/wsf_queue.sv =====
// Short record queue between the front end and the arithmetic back end.
`default_nettype none

module wsf_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire wsf_pkg::wsf_rec_t          push_rec,
  input  wire logic                       pop,
  output logic                            head_valid,
  output wsf_pkg::wsf_rec_t               head_rec,
  output logic [wsf_pkg::QCNT_W-1:0]      level
);
  import wsf_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  wsf_rec_t          slot_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign head_valid = (count_r != '0);
  assign head_rec   = slot_r[rd_ptr_r];
  assign level      = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wsf_back.sv =====
// Back end: expands each record into its results and computes the weighted mean.
`default_nettype none

module wsf_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      head_valid,
  input  wire wsf_pkg::wsf_rec_t         head_rec,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [wsf_pkg::PIX_W-1:0]      out_smoothed,
  output logic [wsf_pkg::POS_W-1:0]      out_row,
  output logic [wsf_pkg::POS_W-1:0]      out_col,
  output logic                           out_last_of_run,
  output logic                           out_frame_end
);
  import wsf_pkg::*;

  localparam int SUM3_W  = PIX_W + 2;
  localparam int SUM9_W  = PIX_W + 4;
  localparam int ACC_W   = PIX_W + 8;
  localparam int MAG_W   = 22;
  localparam int RECIP   = 41944;
  localparam int RECIP_W = 16;
  localparam int RSH     = 22;
  localparam int DIVISOR = 100;
  localparam int CW      = 82;

  // Result order within one record: row above, then the last row, each
  // with the inner column before the right edge column.
  typedef enum logic [1:0] {
    KIND_UP_MID,
    KIND_UP_EDGE,
    KIND_LOW_MID,
    KIND_LOW_EDGE
  } kind_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
    logic             fe;
  } meta_t;

  kind_t                      kind_r, kind_nxt;
  logic                       has_next;
  logic [3:0]                 kind_mask;
  logic                       en, launch;
  col3_t                      sel_l, sel_c, sel_r;
  logic [1:0]                 r_top, r_mid, r_bot;
  meta_t                      meta_new;

  logic                       s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  meta_t                      s1_meta_r, s2_meta_r, s3_meta_r, s4_meta_r;
  logic signed [SUM3_W-1:0]   s1_sl_r, s1_sc_r, s1_sr_r;
  logic signed [PIX_W-1:0]    s1_ctr_r;
  logic signed [SUM9_W-1:0]   s2_s9_r;
  logic signed [ACC_W-1:0]    s2_c82_r;
  logic signed [ACC_W-1:0]    acc;
  logic [MAG_W-1:0]           s3_mag_r, s4_mag_r;
  logic                       s3_neg_r, s4_neg_r;
  logic [PIX_W-1:0]           s4_q0_r;
  logic [MAG_W+RECIP_W-1:0]   prod;
  logic [MAG_W+1:0]           back_mul;
  logic [PIX_W-1:0]           quot;
  logic [PIX_W:0]             signed_q;

  logic                       out_valid_r;
  logic [PIX_W-1:0]           out_smoothed_r;
  meta_t                      out_meta_r;

  function automatic logic signed [SUM3_W-1:0] col_sum(
    input col3_t c, input logic [1:0] a, input logic [1:0] b, input logic [1:0] d
  );
    col_sum = SUM3_W'($signed(c[a])) + SUM3_W'($signed(c[b])) + SUM3_W'($signed(c[d]));
  endfunction

  assign en     = !out_valid_r || !out_stall;
  assign launch = en && head_valid;

  assign kind_mask = {head_rec.last_row & head_rec.has_edge, head_rec.last_row,
                      head_rec.has_edge, 1'b1};

  always_comb begin
    has_next = 1'b0;
    kind_nxt = KIND_UP_MID;
    for (int i = 3; i >= 0; i--) begin
      if ((2'(i) > kind_r) && kind_mask[i]) begin
        has_next = 1'b1;
        kind_nxt = kind_t'(2'(i));
      end
    end
  end

  assign pop = launch && !has_next;

  always_comb begin
    sel_r = head_rec.col_r;
    if (kind_r == KIND_UP_EDGE || kind_r == KIND_LOW_EDGE) begin
      sel_l = head_rec.col_c;
      sel_c = head_rec.col_r;
    end else begin
      sel_l = head_rec.col_l;
      sel_c = head_rec.col_c;
    end
    if (kind_r == KIND_LOW_MID || kind_r == KIND_LOW_EDGE) begin
      r_top = 2'd1;
      r_mid = 2'd2;
      r_bot = 2'd2;
      meta_new.row = head_rec.row;
    end else begin
      r_top = head_rec.top_dup ? 2'd1 : 2'd0;
      r_mid = 2'd1;
      r_bot = 2'd2;
      meta_new.row = head_rec.row - POS_W'(1);
    end
    if (kind_r == KIND_UP_EDGE || kind_r == KIND_LOW_EDGE) begin
      meta_new.col = head_rec.col;
    end else begin
      meta_new.col = head_rec.col - POS_W'(1);
    end
    meta_new.last = !has_next;
    meta_new.fe   = (kind_r == KIND_LOW_EDGE);
  end

  // The weighted sum is 2 * (all nine) + 82 * centre, which is the eight
  // neighbors doubled plus 84 times the centre.
  assign acc  = ACC_W'(s2_s9_r) + ACC_W'(s2_s9_r) + s2_c82_r;
  assign prod = s3_mag_r * RECIP_W'(RECIP);

  // The reciprocal rounds up, so the estimate is exact or one too large.
  assign back_mul = (MAG_W + 2)'(s4_q0_r) * (MAG_W + 2)'(DIVISOR);
  assign quot     = (back_mul > (MAG_W + 2)'(s4_mag_r)) ? s4_q0_r - PIX_W'(1) : s4_q0_r;
  assign signed_q = s4_neg_r ? -{1'b0, quot} : {1'b0, quot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_UP_MID;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      if (launch) begin
        kind_r <= has_next ? kind_nxt : KIND_UP_MID;
      end
      s1_valid_r  <= launch;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sl_r   <= col_sum(sel_l, r_top, r_mid, r_bot);
      s1_sc_r   <= col_sum(sel_c, r_top, r_mid, r_bot);
      s1_sr_r   <= col_sum(sel_r, r_top, r_mid, r_bot);
      s1_ctr_r  <= $signed(sel_c[r_mid]);
      s1_meta_r <= meta_new;

      s2_s9_r   <= SUM9_W'(s1_sl_r) + SUM9_W'(s1_sc_r) + SUM9_W'(s1_sr_r);
      s2_c82_r  <= ACC_W'(s1_ctr_r) * ACC_W'(CW);
      s2_meta_r <= s1_meta_r;

      s3_neg_r  <= acc[ACC_W-1];
      s3_mag_r  <= MAG_W'(acc[ACC_W-1] ? -acc : acc);
      s3_meta_r <= s2_meta_r;

      s4_q0_r   <= prod[RSH +: PIX_W];
      s4_mag_r  <= s3_mag_r;
      s4_neg_r  <= s3_neg_r;
      s4_meta_r <= s3_meta_r;

      out_smoothed_r <= signed_q[PIX_W-1:0];
      out_meta_r     <= s4_meta_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_smoothed    = out_smoothed_r;
  assign out_row         = out_meta_r.row;
  assign out_col         = out_meta_r.col;
  assign out_last_of_run = out_meta_r.last;
  assign out_frame_end   = out_meta_r.fe;

endmodule

`default_nettype wire

// ===== rtl/weighted_3x3_smoothing_filter.sv =====
// Top level of the weighted 3x3 smoothing filter with replicated borders.
//
//   Port group    Direction  Handshake        Transaction
//   cfg_*         in         valid / ready    one write of side_length
//   in_*          in         valid / stall    one pixel in raster order
//   out_*         out        valid / stall    one filtered pixel with position
//
// An interior pixel is taken every cycle while in_stall is low; each pixel of
// the last row leaves two results and its last column four, and the
// single-result arithmetic back end sets that pace. A result passes the front
// register, the queue, stages s1 to s4 and the output register. rst_n is
// synchronous and clears counters, window, queue and pipeline valids; the line
// store needs no clearing. A stall on the result side fills the four-record
// queue; in_stall rises when the queue plus the front register hold four.
`default_nettype none

module weighted_3x3_smoothing_filter #(
  parameter int MAX_SIDE = wsf_pkg::MAX_SIDE_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [wsf_pkg::CFG_W-1:0] cfg_side_length,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [wsf_pkg::PIX_W-1:0] in_pixel,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [wsf_pkg::PIX_W-1:0]      out_smoothed,
  output logic [wsf_pkg::POS_W-1:0]      out_row,
  output logic [wsf_pkg::POS_W-1:0]      out_col,
  output logic                           out_last_of_run,
  output logic                           out_frame_end
);
  import wsf_pkg::*;

  logic              cfg_we;
  logic              push, pop, head_valid;
  wsf_rec_t          push_rec, head_rec;
  logic [QCNT_W-1:0] q_level;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  wsf_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_side_length(cfg_side_length),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .q_level        (q_level),
    .push           (push),
    .rec            (push_rec)
  );

  wsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .head_valid(head_valid),
    .head_rec  (head_rec),
    .level     (q_level)
  );

  wsf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_rec       (head_rec),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_smoothed   (out_smoothed),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_last_of_run(out_last_of_run),
    .out_frame_end  (out_frame_end)
  );

endmodule

`default_nettype wire
